### hw/rtl/phfe_pkg.sv
// Package for the packet header field extractor.
// Holds the result word type, field ids, status codes and header layout constants.
// No dependencies.
package phfe_pkg;

    localparam int FIELD_ID_W = 5;
    localparam int VALUE_W    = 16;
    localparam int STATUS_W   = 2;

    // Header layout: fixed head, password, then zone/product/cap area and trailing bytes
    localparam int FIXED_HEAD     = 26;
    localparam int WORD_AREA_END  = 24;
    localparam int ZONE_AREA_LEN  = 20;
    localparam int TAIL_LEN       = 4;

    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;

    localparam logic CFG_DEFAULT_ZONE     = 1'b0;
    localparam logic CFG_EXPECTED_VERSION = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_VER   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd2;

    localparam logic [FIELD_ID_W-1:0] FID_VERSION  = 5'd9;
    localparam logic [FIELD_ID_W-1:0] FID_PROD_LO  = 5'd12;
    localparam logic [FIELD_ID_W-1:0] FID_REV_MAJ  = 5'd13;
    localparam logic [FIELD_ID_W-1:0] FID_PASSWORD = 5'd14;
    localparam logic [FIELD_ID_W-1:0] FID_PROD_HI  = 5'd15;
    localparam logic [FIELD_ID_W-1:0] FID_REV_MIN  = 5'd16;
    localparam logic [FIELD_ID_W-1:0] FID_CAPWORD  = 5'd17;
    localparam logic [FIELD_ID_W-1:0] FID_ORIG_ZONE  = 5'd18;
    localparam logic [FIELD_ID_W-1:0] FID_DEST_ZONE  = 5'd19;
    localparam logic [FIELD_ID_W-1:0] FID_ORIG_POINT = 5'd20;
    localparam logic [FIELD_ID_W-1:0] FID_DEST_POINT = 5'd21;
    localparam logic [FIELD_ID_W-1:0] FID_DONE       = 5'd22;

    typedef struct packed {
        logic [FIELD_ID_W-1:0] field_id;
        logic [VALUE_W-1:0]    field_value;
        logic [STATUS_W-1:0]   status;
        logic                  last;
    } result_t;

endpackage

### hw/rtl/phfe_parser.sv
// Header parser: byte offset, holds and zone/capability state, one byte per step.
// Depends on phfe_pkg.
module phfe_parser #(
    parameter int PASSWORD_LEN = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic                  mode,
    input  logic [7:0]            data_byte,
    input  logic [15:0]           default_zone,
    input  logic [15:0]           expected_version,
    output logic                  result_valid,
    output phfe_pkg::result_t     result
);

    localparam int HDR_LEN = phfe_pkg::FIXED_HEAD + PASSWORD_LEN
                           + phfe_pkg::ZONE_AREA_LEN + phfe_pkg::TAIL_LEN;
    localparam int OW    = $clog2(HDR_LEN + 1);
    localparam int REL_W = 5;

    localparam logic [OW-1:0] OFF_WORD_END = OW'(phfe_pkg::WORD_AREA_END);
    localparam logic [OW-1:0] OFF_PROD_LO  = OW'(phfe_pkg::WORD_AREA_END);
    localparam logic [OW-1:0] OFF_REV_MAJ  = OW'(phfe_pkg::WORD_AREA_END + 1);
    localparam logic [OW-1:0] OFF_ZSTART   = OW'(phfe_pkg::FIXED_HEAD + PASSWORD_LEN);

    // offsets relative to the zone area
    localparam logic [REL_W-1:0] REL_ORIG_ZONE_HI = 5'd1;
    localparam logic [REL_W-1:0] REL_DEST_ZONE_HI = 5'd3;
    localparam logic [REL_W-1:0] REL_SPARE_HI     = 5'd5;
    localparam logic [REL_W-1:0] REL_CAPSWAP_LO   = 5'd6;
    localparam logic [REL_W-1:0] REL_CAPSWAP_HI   = 5'd7;
    localparam logic [REL_W-1:0] REL_PROD_HI      = 5'd8;
    localparam logic [REL_W-1:0] REL_REV_MIN      = 5'd9;
    localparam logic [REL_W-1:0] REL_CAPWORD_HI   = 5'd11;
    localparam logic [REL_W-1:0] REL_OZONE_HI     = 5'd13;
    localparam logic [REL_W-1:0] REL_DZONE_HI     = 5'd15;
    localparam logic [REL_W-1:0] REL_OPOINT_HI    = 5'd17;
    localparam logic [REL_W-1:0] REL_DPOINT_HI    = 5'd19;
    localparam logic [REL_W-1:0] REL_LAST =
        REL_W'(phfe_pkg::ZONE_AREA_LEN + phfe_pkg::TAIL_LEN - 1);

    typedef enum logic {
        PH_RECV,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [OW-1:0] offset_reg, offset_next;
    logic [7:0]  low_hold_reg, low_hold_next;
    logic [15:0] swap_cap_reg, swap_cap_next;
    logic [15:0] cap_valid_reg, cap_valid_next;
    logic [15:0] lzone0_reg, lzone0_next;
    logic [15:0] lzone1_reg, lzone1_next;

    logic [15:0]      word;
    logic [OW-1:0]    rel_full;
    logic [REL_W-1:0] rel;

    function automatic logic [15:0] pick_zone(
        input logic [15:0] dflt,
        input logic [15:0] legacy,
        input logic [15:0] ext,
        input logic        cap_ok
    );
        logic [15:0] z;
        z = dflt;
        if (legacy != 16'd0)
            z = legacy;
        if (cap_ok && ext != 16'd0)
            z = ext;
        return z;
    endfunction

    assign word     = {data_byte, low_hold_reg};
    assign rel_full = offset_reg - OFF_ZSTART;
    assign rel      = rel_full[REL_W-1:0];

    always_comb
    begin
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        low_hold_next  = low_hold_reg;
        swap_cap_next  = swap_cap_reg;
        cap_valid_next = cap_valid_reg;
        lzone0_next    = lzone0_reg;
        lzone1_next    = lzone1_reg;
        result_valid       = 1'b0;
        result.field_id    = phfe_pkg::FID_DONE;
        result.field_value = word;
        result.status      = phfe_pkg::ST_OK;
        result.last        = 1'b0;

        if (mode == phfe_pkg::MODE_END)
        begin
            if (phase_reg == PH_RECV && offset_reg != '0)
            begin
                result_valid       = 1'b1;
                result.field_id    = phfe_pkg::FID_DONE;
                result.field_value = 16'(offset_reg);
                result.status      = phfe_pkg::ST_TRUNCATED;
                result.last        = 1'b1;
            end
            phase_next     = PH_RECV;
            offset_next    = '0;
            low_hold_next  = '0;
            swap_cap_next  = '0;
            cap_valid_next = '0;
            lzone0_next    = '0;
            lzone1_next    = '0;
        end
        else if (phase_reg == PH_RECV)
        begin
            offset_next = offset_reg + 1'b1;
            if (offset_reg < OFF_WORD_END)
            begin
                if (!offset_reg[0])
                    low_hold_next = data_byte;
                else
                begin
                    result_valid    = 1'b1;
                    result.field_id = {1'b0, offset_reg[4:1]};
                    if (result.field_id == phfe_pkg::FID_VERSION && word != expected_version)
                    begin
                        phase_next    = PH_DONE;
                        result.status = phfe_pkg::ST_BAD_VER;
                        result.last   = 1'b1;
                    end
                end
            end
            else if (offset_reg == OFF_PROD_LO)
            begin
                result_valid       = 1'b1;
                result.field_id    = phfe_pkg::FID_PROD_LO;
                result.field_value = {8'd0, data_byte};
            end
            else if (offset_reg == OFF_REV_MAJ)
            begin
                result_valid       = 1'b1;
                result.field_id    = phfe_pkg::FID_REV_MAJ;
                result.field_value = {8'd0, data_byte};
            end
            else if (offset_reg < OFF_ZSTART)
            begin
                result_valid       = 1'b1;
                result.field_id    = phfe_pkg::FID_PASSWORD;
                result.field_value = {8'd0, data_byte};
            end
            else
            begin
                case (rel)
                    REL_ORIG_ZONE_HI: lzone0_next = word;
                    REL_DEST_ZONE_HI: lzone1_next = word;
                    REL_SPARE_HI: ;
                    REL_CAPSWAP_HI: swap_cap_next = {low_hold_reg, data_byte};
                    REL_PROD_HI:
                    begin
                        result_valid       = 1'b1;
                        result.field_id    = phfe_pkg::FID_PROD_HI;
                        result.field_value = {8'd0, data_byte};
                    end
                    REL_REV_MIN:
                    begin
                        result_valid       = 1'b1;
                        result.field_id    = phfe_pkg::FID_REV_MIN;
                        result.field_value = {8'd0, data_byte};
                    end
                    REL_CAPWORD_HI:
                    begin
                        cap_valid_next = (word != 16'd0 && word == swap_cap_reg) ? word : 16'd0;
                        result_valid       = 1'b1;
                        result.field_id    = phfe_pkg::FID_CAPWORD;
                        result.field_value = cap_valid_next;
                    end
                    REL_OZONE_HI:
                    begin
                        result_valid       = 1'b1;
                        result.field_id    = phfe_pkg::FID_ORIG_ZONE;
                        result.field_value = pick_zone(default_zone, lzone0_reg, word,
                                                       cap_valid_reg != 16'd0);
                    end
                    REL_DZONE_HI:
                    begin
                        result_valid       = 1'b1;
                        result.field_id    = phfe_pkg::FID_DEST_ZONE;
                        result.field_value = pick_zone(default_zone, lzone1_reg, word,
                                                       cap_valid_reg != 16'd0);
                    end
                    REL_OPOINT_HI:
                    begin
                        result_valid       = 1'b1;
                        result.field_id    = phfe_pkg::FID_ORIG_POINT;
                        result.field_value = (cap_valid_reg != 16'd0) ? word : 16'd0;
                    end
                    REL_DPOINT_HI:
                    begin
                        result_valid       = 1'b1;
                        result.field_id    = phfe_pkg::FID_DEST_POINT;
                        result.field_value = (cap_valid_reg != 16'd0) ? word : 16'd0;
                    end
                    REL_LAST:
                    begin
                        phase_next         = PH_DONE;
                        result_valid       = 1'b1;
                        result.field_id    = phfe_pkg::FID_DONE;
                        result.field_value = 16'd0;
                        result.last        = 1'b1;
                    end
                    default:
                    begin
                        // even offsets in the zone area hold the low byte
                        if (!rel[0] || rel == REL_CAPSWAP_LO)
                            low_hold_next = data_byte;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RECV;
            offset_reg    <= '0;
            low_hold_reg  <= '0;
            swap_cap_reg  <= '0;
            cap_valid_reg <= '0;
            lzone0_reg    <= '0;
            lzone1_reg    <= '0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            offset_reg    <= offset_next;
            low_hold_reg  <= low_hold_next;
            swap_cap_reg  <= swap_cap_next;
            cap_valid_reg <= cap_valid_next;
            lzone0_reg    <= lzone0_next;
            lzone1_reg    <= lzone1_next;
        end
    end

endmodule

### hw/rtl/phfe_out_stage.sv
// Result register: holds one result word until the consumer takes it.
// Depends on phfe_pkg.
module phfe_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  phfe_pkg::result_t load_data,
    input  logic              ready,
    output logic              valid,
    output logic              free,
    output phfe_pkg::result_t data
);

    logic              valid_reg, valid_next;
    phfe_pkg::result_t data_reg;

    assign free = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

### hw/rtl/packet_header_field_extractor.sv
// Packet header field extractor, top level.
// Path: input register -> parser logic -> result register.
// Throughput: one word per cycle while the result register is free to take a word.
// Words that give no result pass through the parser without using the result register.
// Reset (async, active low) clears the parser state and both valid flags;
// config registers return to default_zone = 1, expected_version = 2.
module packet_header_field_extractor #(
    parameter int PASSWORD_LEN = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // header byte channel
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    // result channel
    output logic        result_valid,
    input  logic        result_ready,
    output logic [4:0]  field_id,
    output logic [15:0] field_value,
    output logic [1:0]  status,
    output logic        last,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    // config registers
    logic [15:0] default_zone_reg;
    logic [15:0] expected_version_reg;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic       in_mode_reg;
    logic [7:0] in_byte_reg;

    logic              advance;
    logic              out_free;
    logic              step_result_valid;
    phfe_pkg::result_t step_result;
    phfe_pkg::result_t out_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_zone_reg     <= 16'd1;
            expected_version_reg <= 16'd2;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                phfe_pkg::CFG_DEFAULT_ZONE:     default_zone_reg     <= cfg_data;
                phfe_pkg::CFG_EXPECTED_VERSION: expected_version_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // the parser steps whenever a word is waiting and the result register can take a word
    assign advance    = in_valid_reg && out_free;
    assign item_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_valid && item_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_mode_reg <= mode;
            in_byte_reg <= data_byte;
        end
    end

    phfe_parser #(
        .PASSWORD_LEN (PASSWORD_LEN)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (advance),
        .mode             (in_mode_reg),
        .data_byte        (in_byte_reg),
        .default_zone     (default_zone_reg),
        .expected_version (expected_version_reg),
        .result_valid     (step_result_valid),
        .result           (step_result)
    );

    phfe_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && step_result_valid),
        .load_data (step_result),
        .ready     (result_ready),
        .valid     (result_valid),
        .free      (out_free),
        .data      (out_word)
    );

    assign field_id    = out_word.field_id;
    assign field_value = out_word.field_value;
    assign status      = out_word.status;
    assign last        = out_word.last;

endmodule
